@@ hw/rtl/aavc_pkg.sv @@
// ----------------------------------------------------------------------------
// aavc_pkg - shared types and constants of the ADC average voltage calibrator
// Calibration table, field widths, register indexes, status codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aavc_pkg;

   // Field widths
   localparam int ADC_BITS     = 12;
   localparam int TABLE_POINTS = 11;
   localparam int SEG_W        = 4;
   localparam int SUM_W        = 28;
   localparam int CNT_W        = 16;
   localparam int DIVR_W       = 16;
   localparam int STEP_W       = $clog2(SUM_W);
   localparam int VOLT_W       = 15;
   localparam int BASE_W       = 6;
   localparam int FRAC_W       = 9;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
   localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VOLTS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_THR   = 2'd2;

   // Register reset values
   localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT = 16'd3000;
   localparam logic [BASE_W-1:0] RST_BASE_VOLTS   = 6'd20;
   localparam logic [VOLT_W-1:0] RST_CHARGE_THR   = 15'd6810;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_OVER  = 2'd1,
      STATUS_UNDER = 2'd2,
      STATUS_FAULT = 2'd3
   } status_type;

   // Calibration breakpoints; entry k stands for base_volts + k volts
   localparam logic [ADC_BITS-1:0] BREAKPOINTS [TABLE_POINTS] = '{
      12'd2192, 12'd2311, 12'd2432, 12'd2559, 12'd2679, 12'd2800,
      12'd2928, 12'd3071, 12'd3216, 12'd3331, 12'd3474
   };

   // Look up one breakpoint; indexes past the table read as zero
   function automatic logic [ADC_BITS-1:0] bp_at(input logic [SEG_W-1:0] idx);
      logic [ADC_BITS-1:0] val;
      val = '0;
      for (int i = 0; i < TABLE_POINTS; i++) begin
         if (idx == SEG_W'(i)) begin
            val = BREAKPOINTS[i];
         end
      end
      return val;
   endfunction

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;      // take one sample word
      logic close;       // this sample ends the window, start mean divide
      logic mean_load;   // capture divider quotient as mean
      logic seg_init;    // start segment search at the second breakpoint
      logic seg_inc;     // advance segment search
      logic frac_start;  // start fraction divide
      logic res_load;    // capture result fields
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic window_end;  // next sample closes the window
      logic div_done;    // divider quotient ready
      logic in_table;    // mean lies inside the table
      logic search_more; // mean is above the current breakpoint
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/aavc_div.sv @@
// ----------------------------------------------------------------------------
// aavc_div - iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step,
// with the quotient stable until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aavc_div import aavc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic      [SUM_W-1:0]  quotient,
   output logic                   done
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              fits;

   // Shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = ~diff[DIVR_W];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

@@ hw/rtl/aavc_datapath.sv @@
// ----------------------------------------------------------------------------
// aavc_datapath - accumulator, divider, table lookup and result registers
// Sums samples, holds the configuration registers, divides for the mean and
// the interpolation fraction, and builds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aavc_datapath import aavc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [ADC_BITS-1:0]   req_adc_sample,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              st,
   output logic      [VOLT_W-1:0]     rsp_voltage_q8,
   output logic      [ADC_BITS-1:0]   rsp_mean_code,
   output logic      [SEG_W-1:0]      rsp_segment,
   output logic      [1:0]            rsp_status,
   output logic                       rsp_charging
);

   // Configuration registers
   logic [CNT_W-1:0]  count_cfg_ff;
   logic [BASE_W-1:0] base_cfg_ff;
   logic [VOLT_W-1:0] thr_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= RST_SAMPLE_COUNT;
         base_cfg_ff  <= RST_BASE_VOLTS;
         thr_cfg_ff   <= RST_CHARGE_THR;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: count_cfg_ff <= csr_wdata;
            CSR_BASE_VOLTS:   base_cfg_ff  <= csr_wdata[BASE_W-1:0];
            CSR_CHARGE_THR:   thr_cfg_ff   <= csr_wdata[VOLT_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturating accumulator and window counter
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_next;
   logic [CNT_W-1:0] cnt_next;
   logic [CNT_W-1:0] n_eff;

   assign n_eff    = (count_cfg_ff == '0) ? CNT_W'(1) : count_cfg_ff;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(req_adc_sample);
   assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign cnt_next = cnt_ff + 1'b1;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.close) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (cmd.accept) begin
         sum_in = sum_next;
         cnt_in = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   // Mean and segment registers
   logic [ADC_BITS-1:0] mean_ff;
   logic [SEG_W-1:0]    k_ff;
   logic [SUM_W-1:0]    quotient;
   logic                div_done;

   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         mean_ff <= (quotient > SUM_W'(FULL_SCALE)) ? FULL_SCALE
                                                    : quotient[ADC_BITS-1:0];
      end
      if (cmd.seg_init) begin
         k_ff <= SEG_W'(1);
      end else if (cmd.seg_inc) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // Segment ends and fraction operands
   logic [ADC_BITS-1:0] lo;
   logic [ADC_BITS-1:0] hi;
   logic [ADC_BITS-1:0] span;
   logic [ADC_BITS-1:0] offset;

   assign lo     = bp_at(k_ff - 1'b1);
   assign hi     = bp_at(k_ff);
   assign span   = hi - lo;
   assign offset = mean_ff - lo;

   // Shared divider: mean at window close, fraction after the search
   logic              div_start;
   logic [SUM_W-1:0]  div_dividend;
   logic [DIVR_W-1:0] div_divisor;

   assign div_start    = cmd.close | cmd.frac_start;
   assign div_dividend = cmd.close ? sum_next : SUM_W'({offset, 8'h00});
   assign div_divisor  = cmd.close ? n_eff : DIVR_W'(span);

   aavc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // Classify the mean
   status_type status_now;

   always_comb begin
      if (mean_ff >= FULL_SCALE) begin
         status_now = STATUS_FAULT;
      end else if (mean_ff < BREAKPOINTS[0]) begin
         status_now = STATUS_UNDER;
      end else if (mean_ff > BREAKPOINTS[TABLE_POINTS-1]) begin
         status_now = STATUS_OVER;
      end else begin
         status_now = STATUS_OK;
      end
   end

   // Interpolated voltage
   logic [SEG_W-1:0]  seg_now;
   logic [FRAC_W-1:0] frac;
   logic [VOLT_W-9:0] volts_whole;
   logic [VOLT_W-1:0] volts;
   logic              status_ok;

   assign status_ok   = (status_now == STATUS_OK);
   assign seg_now     = k_ff - 1'b1;
   assign frac        = (span == '0) ? '0 : quotient[FRAC_W-1:0];
   assign volts_whole = (VOLT_W - 8)'(base_cfg_ff) + (VOLT_W - 8)'(seg_now);
   assign volts       = {volts_whole, 8'h00} + VOLT_W'(frac);

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_mean_code  <= mean_ff;
         rsp_status     <= status_now;
         rsp_voltage_q8 <= status_ok ? volts : '0;
         rsp_segment    <= status_ok ? seg_now : '0;
         rsp_charging   <= status_ok && (volts > thr_cfg_ff);
      end
   end

   // Status toward the controller
   assign st.window_end  = (cnt_next == '0) || (cnt_next >= n_eff);
   assign st.div_done    = div_done;
   assign st.in_table    = status_ok;
   assign st.search_more = (k_ff < SEG_W'(TABLE_POINTS - 1)) && (mean_ff > hi);

endmodule

`default_nettype wire

@@ hw/rtl/aavc_ctrl.sv @@
// ----------------------------------------------------------------------------
// aavc_ctrl - sequencer of the averaging back stage
// Gates sample acceptance, steps mean divide, segment search and fraction
// divide, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aavc_ctrl import aavc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type st,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_MEAN     = 5'b00010,
      ST_CLASSIFY = 5'b00100,
      ST_SEARCH   = 5'b01000,
      ST_FRAC     = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      stage_free;

   // Hold a window-closing sample while the back stage or result is busy
   assign stage_free = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_ready  = !st.window_end || stage_free;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.accept     = req_valid && req_ready;
      cmd.close      = cmd.accept && st.window_end;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.close) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (st.div_done) begin
               cmd.mean_load = 1'b1;
               state_in      = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (st.in_table) begin
               cmd.seg_init = 1'b1;
               state_in     = ST_SEARCH;
            end else begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (st.search_more) begin
               cmd.seg_inc = 1'b1;
            end else begin
               cmd.frac_start = 1'b1;
               state_in       = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (st.div_done) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Raise valid on a new result, drop it when the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_close_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.close |-> stage_free)
      else $error("window closed while back stage busy");

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      st.div_done |-> (state_ff == ST_MEAN || state_ff == ST_FRAC))
      else $error("divider finished outside a wait state");

   a_mean_then_classify: assert property (@(posedge clock) disable iff (reset)
      cmd.mean_load |=> (state_ff == ST_CLASSIFY))
      else $error("mean capture not followed by classify");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/adc_average_voltage_calibrator.sv @@
// ----------------------------------------------------------------------------
// adc_average_voltage_calibrator - averaged ADC reading to calibrated voltage
// Averages a window of converter samples and maps the mean through a
// piecewise linear table to a voltage in 1/256 V with range status.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 12-bit sample per word, taken every cycle while ready.
//   rsp_*  : one result word per window of sample_count samples.
//   csr_*  : register writes (0 sample_count, 1 base_volts, 2 charge
//            threshold), always ready; write only while the block is idle.
// Sequence: from the sample that closes a window to rsp_valid, an
//   out-of-table mean takes one divide, and inside the table the steps
//   are mean divide, segment search and fraction divide, both divides on
//   the shared one-bit-per-cycle divider.
// Throughput: one sample per cycle. The sample that closes a window waits
//   while the previous result is still being computed or is not yet taken.
// Stall: with rsp_ready low the result word holds and accumulation goes on
//   until the next window closes.
// Reset: clears the accumulator, the window count and rsp_valid, and loads
//   the register defaults (3000 samples, 20 V, 6810/256 V).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adc_average_voltage_calibrator import aavc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ADC_BITS-1:0]   req_adc_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [VOLT_W-1:0]     rsp_voltage_q8,
   output logic      [ADC_BITS-1:0]   rsp_mean_code,
   output logic      [SEG_W-1:0]      rsp_segment,
   output logic      [1:0]            rsp_status,
   output logic                       rsp_charging,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   aavc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   aavc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_adc_sample (req_adc_sample),
      .cmd            (cmd),
      .st             (st),
      .rsp_voltage_q8 (rsp_voltage_q8),
      .rsp_mean_code  (rsp_mean_code),
      .rsp_segment    (rsp_segment),
      .rsp_status     (rsp_status),
      .rsp_charging   (rsp_charging)
   );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench of the ADC average voltage calibrator
// Feeds sample words through the valid/ready request channel, programs the
// window length, base voltage and charge threshold between phases, and checks
// every result word against a cycle-free predictor of the averaging window and
// the piecewise linear calibration. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import aavc_pkg::*;

   localparam int          CODE_MAX     = (1 << ADC_BITS) - 1;
   localparam int unsigned SUM_LIMIT    = (1 << SUM_W) - 1;
   localparam int          RANDOM_ITEMS = 800;
   localparam int          DRAIN_CYCLES = 120;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          QUIET_LIMIT  = 3000;
   localparam int          PRINT_CAP    = 40;

   // Calibration knees: knee k stands for base_volts + k volts
   localparam int unsigned KNEE [TABLE_POINTS] = '{
      2192, 2311, 2432, 2559, 2679, 2800, 2928, 3071, 3216, 3331, 3474
   };

   typedef struct {
      logic [VOLT_W-1:0]   voltage;
      logic [ADC_BITS-1:0] mean;
      logic [SEG_W-1:0]    segment;
      status_type          status;
      logic                charging;
   } reading_type;

   // Averaging window and calibration predictor with its queue of due readings
   class window_calibrator;
      int unsigned window_len;
      int unsigned base_v;
      int unsigned charge_thr;
      int unsigned acc_sum;
      int unsigned acc_cnt;
      reading_type due_readings[$];
      int unsigned errors;
      int unsigned samples_taken;
      int unsigned by_status[4];
      int unsigned charged;

      function new();
         window_len = RST_SAMPLE_COUNT;
         base_v = RST_BASE_VOLTS;
         charge_thr = RST_CHARGE_THR;
         acc_sum = 0;
         acc_cnt = 0;
         errors = 0;
         samples_taken = 0;
         charged = 0;
         foreach (by_status[i]) by_status[i] = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_COUNT: window_len = data;
            CSR_BASE_VOLTS:   base_v = data[BASE_W-1:0];
            CSR_CHARGE_THR:   charge_thr = data[VOLT_W-1:0];
            default: ;
         endcase
      endfunction

      // Map a window mean to voltage, segment and range status
      function reading_type calibrate(input int unsigned mean);
         reading_type r;
         int unsigned k, lo, hi, frac, volts;
         r.voltage = '0;
         r.mean = mean[ADC_BITS-1:0];
         r.segment = '0;
         r.status = STATUS_OK;
         r.charging = 1'b0;
         if (mean >= CODE_MAX) begin
            r.status = STATUS_FAULT;
         end else if (mean < KNEE[0]) begin
            r.status = STATUS_UNDER;
         end else if (mean > KNEE[TABLE_POINTS-1]) begin
            r.status = STATUS_OVER;
         end else begin
            // first knee at or above the mean closes the segment
            k = 1;
            while (k < TABLE_POINTS - 1 && mean > KNEE[k]) k++;
            lo = KNEE[k-1];
            hi = KNEE[k];
            frac = 0;
            if (hi > lo && mean >= lo) frac = ((mean - lo) * 256) / (hi - lo);
            volts = (base_v + k - 1) * 256 + frac;
            r.voltage = volts[VOLT_W-1:0];
            r.segment = SEG_W'(k - 1);
            r.charging = (volts > charge_thr);
         end
         return r;
      endfunction

      // Accumulate one accepted sample word; close the window when it is full
      function void take_sample(input logic [ADC_BITS-1:0] code);
         int unsigned n, cnt, mean;
         reading_type r;
         samples_taken++;
         n = (window_len == 0) ? 1 : window_len;
         if (SUM_LIMIT - acc_sum < code) acc_sum = SUM_LIMIT;
         else acc_sum += code;
         cnt = (acc_cnt + 1) & 32'hFFFF;
         if (cnt != 0 && cnt < n) begin
            acc_cnt = cnt;
            return;
         end
         mean = acc_sum / n;
         if (mean > CODE_MAX) mean = CODE_MAX;
         r = calibrate(mean);
         due_readings.push_back(r);
         by_status[r.status]++;
         if (r.charging) charged++;
         acc_sum = 0;
         acc_cnt = 0;
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      // Compare one accepted result word with the oldest due reading
      task match_reading(input logic [VOLT_W-1:0] voltage,
                         input logic [ADC_BITS-1:0] mean,
                         input logic [SEG_W-1:0] segment,
                         input logic [1:0] status,
                         input logic charging);
         reading_type want;
         if (due_readings.size() == 0) begin
            report("result word with no window closed");
            return;
         end
         want = due_readings.pop_front();
         if (voltage !== want.voltage)
            report($sformatf("voltage_q8 %0d, want %0d", voltage, want.voltage));
         if (mean !== want.mean)
            report($sformatf("mean_code %0d, want %0d", mean, want.mean));
         if (segment !== want.segment)
            report($sformatf("segment %0d, want %0d", segment, want.segment));
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (charging !== want.charging)
            report($sformatf("charging %0b, want %0b", charging, want.charging));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADC_BITS-1:0]   req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VOLT_W-1:0]     rsp_voltage_q8;
   logic [ADC_BITS-1:0]   rsp_mean_code;
   logic [SEG_W-1:0]      rsp_segment;
   logic [1:0]            rsp_status;
   logic                  rsp_charging;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   window_calibrator calib = new();

   logic [ADC_BITS-1:0] batch[$];
   int unsigned         samples_sent = 0;
   int unsigned         burst_left = 0;
   bit                  no_gaps = 1'b0;
   int unsigned         hold_asks = 0;
   int unsigned         programs = 0;
   int unsigned         quiet_cycles = 0;

   adc_average_voltage_calibrator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_voltage_q8 (rsp_voltage_q8),
      .rsp_mean_code  (rsp_mean_code),
      .rsp_segment    (rsp_segment),
      .rsp_status     (rsp_status),
      .rsp_charging   (rsp_charging),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every result word taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         calib.match_reading(rsp_voltage_q8, rsp_mean_code, rsp_segment, rsp_status,
                             rsp_charging);
   end

   // Abort when no channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random ready pattern, long clean runs, and a long hold on request
   initial begin
      int unsigned run_left, hold_left, hold_seen;
      logic        grant;
      run_left = 0;
      hold_left = 0;
      hold_seen = 0;
      grant = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     grant = 1'b1;
                     run_left = 80;
                  end
                  1, 2, 3: begin
                     grant = 1'b0;
                     run_left = $urandom_range(1, 12);
                  end
                  default: begin
                     grant = 1'b1;
                     run_left = $urandom_range(1, 8);
                  end
               endcase
            end
            run_left--;
            rsp_ready <= grant;
         end
      end
   end

   // Drop valid and idle for a time set by n; n is at least one
   task automatic idle_req(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Offer one sample word, wait for it to be taken, then pace the next
   task automatic push_sample(input logic [ADC_BITS-1:0] code);
      req_valid <= 1'b1;
      req_adc_sample <= code;
      do @(posedge clock); while (!req_ready);
      calib.take_sample(code);
      samples_sent++;
      @(negedge clock);
      if (no_gaps) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 9));
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      calib.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic program_regs(input int unsigned count, input int unsigned base,
                               input int unsigned thr);
      csr_write(CSR_SAMPLE_COUNT, CSR_DATA_W'(count));
      csr_write(CSR_BASE_VOLTS, CSR_DATA_W'(base));
      csr_write(CSR_CHARGE_THR, CSR_DATA_W'(thr));
      csr_valid <= 1'b0;
      programs++;
   endtask

   // Hold the sender until every reading is in and the back stage is quiet
   task automatic settle();
      idle_req(1);
      while (calib.due_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Fill the rest of the current window so that its mean lands near a target
   // picked by class: noise, inside the table, on a knee, below, above, full
   // scale or one code short of it
   function automatic void plan_window(input int unsigned pick);
      int win, left, target, spread, total, acc, s, i;
      batch.delete();
      win = (calib.window_len == 0) ? 1 : int'(calib.window_len);
      left = (int'(calib.acc_cnt) >= win) ? 1 : win - int'(calib.acc_cnt);
      spread = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 300));
      if (pick < 15) target = -1;
      else if (pick < 55) target = $urandom_range(KNEE[0], KNEE[TABLE_POINTS-1]);
      else if (pick < 70)
         target = int'(KNEE[$urandom_range(0, TABLE_POINTS-1)]) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 78) target = $urandom_range(0, KNEE[0] - 1);
      else if (pick < 86) target = $urandom_range(KNEE[TABLE_POINTS-1] + 1, CODE_MAX - 1);
      else if (pick < 93) target = CODE_MAX;
      else target = CODE_MAX - 1;
      total = (target < 0) ? 0 : target * win + int'($urandom_range(0, win - 1));
      acc = int'(calib.acc_sum);
      for (i = 0; i < left; i++) begin
         if (target < 0) s = $urandom_range(0, CODE_MAX);
         else if (i == left - 1) s = total - acc;
         else s = target + int'($urandom_range(0, 2 * spread)) - spread;
         if (s < 0) s = 0;
         if (s > CODE_MAX) s = CODE_MAX;
         acc += s;
         batch.push_back(ADC_BITS'(s));
      end
   endfunction

   task automatic run_window(input int unsigned pick);
      plan_window(pick);
      foreach (batch[i]) push_sample(batch[i]);
   endtask

   // Main sequence
   initial begin
      logic [ADC_BITS-1:0] edge_codes[$];
      int unsigned         rand_base, goal, phase, count, base, thr;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // one short window with base voltage and threshold at their reset values
      csr_write(CSR_SAMPLE_COUNT, CSR_DATA_W'(4));
      csr_valid <= 1'b0;
      run_window(40);

      // one-sample windows over the code extremes and every knee
      settle();
      program_regs(1, 0, 0);
      edge_codes = '{12'd0, 12'd4095, 12'd2191, 12'd3475, 12'd2250, 12'hAAA};
      foreach (KNEE[i]) edge_codes.push_back(ADC_BITS'(KNEE[i]));
      foreach (edge_codes[i]) push_sample(edge_codes[i]);

      // zero window length acts as one; top of the table at the top base
      settle();
      program_regs(0, 63, 18688);
      push_sample(12'd2700);
      push_sample(12'd3474);

      // shrink the window after four full-scale samples: sum over one sample
      settle();
      program_regs(8, 5, 1500);
      repeat (4) push_sample(12'd4095);
      settle();
      program_regs(1, 5, 1500);
      push_sample(12'd4095);

      // shrink the window below the samples already taken
      settle();
      program_regs(6, 40, 11000);
      repeat (3) push_sample(12'd1400);
      settle();
      program_regs(2, 40, 11000);
      push_sample(12'd1400);

      // random phases; the first one runs into a long receiver hold
      rand_base = samples_sent;
      phase = 0;
      while (samples_sent - rand_base < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = $urandom_range(7, 48);
            default: count = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 5))
            0:       base = 0;
            1:       base = 63;
            default: base = $urandom_range(0, 63);
         endcase
         case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 18688;
            default: thr = (base + $urandom_range(0, 10)) * 256 + $urandom_range(0, 255);
         endcase
         if (thr > 18688) thr = 18688;
         if (phase == 0) count = 2;
         program_regs(count, base, thr);
         if (phase == 0) begin
            no_gaps = 1'b1;
            hold_asks++;
         end
         goal = samples_sent + $urandom_range(60, 160);
         while (samples_sent < goal) run_window($urandom_range(0, 99));
         no_gaps = 1'b0;
         phase++;
      end

      // a long window, back to back
      settle();
      program_regs(200, 17, 9000);
      no_gaps = 1'b1;
      run_window(40);
      no_gaps = 1'b0;

      // drain and report
      settle();
      $display("summary: %0d samples, %0d readings (ok %0d, over %0d, under %0d, fault %0d),",
               calib.samples_taken, calib.by_status[0] + calib.by_status[1] +
               calib.by_status[2] + calib.by_status[3], calib.by_status[STATUS_OK],
               calib.by_status[STATUS_OVER], calib.by_status[STATUS_UNDER],
               calib.by_status[STATUS_FAULT]);
      $display("summary: %0d charging, %0d register programs, windows of 0 to 200 samples",
               calib.charged, programs);
      if (calib.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", calib.errors);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
